>>> design/lruc_pkg.sv
package lruc_pkg;

  // default sizing, handed to the top level as parameter defaults
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;

  // fixed port widths
  localparam int KEY_W  = 32;
  localparam int CNT_W  = 32;
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

endpackage

>>> design/lru_cache_hit_counter_top.sv
// Fully associative LRU cache directory with hit and access counters.
// Each input beat carries one key reference; each result beat reports hit or
// miss, the key evicted on a miss into a full directory (zero when nothing was
// evicted), and the saturating hit and access counts including this beat.
// Throughput is one beat per clock while no stalled result beat is held: a key
// is captured in an input register, and the tag compare against every entry,
// the rank update and the counter update happen in the cycle that moves it
// into the result register, which raises out_valid; while a result beat is
// stalled, the next key waits in the input register and in_stall
// rises only when the input register holds a key and the result register is
// full and stalled. The capacity register (byte address 0, reset 16) sets how
// many entries are used; 0 acts as 1 and values above ENTRIES act as ENTRIES.
// Writing it invalidates every entry at once; the counters keep counting.
// Write capacity only while no beat is in flight. Keys are compared on their
// low KEY_BITS bits (all 32 when KEY_BITS is 32 or more).
module lru_cache_hit_counter_top #(
  parameter int ENTRIES  = lruc_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lruc_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lruc_pkg::KEY_W-1:0]  in_key,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic                        out_evicted_valid,
  output logic [lruc_pkg::KEY_W-1:0]  out_evicted_key,
  output logic [lruc_pkg::CNT_W-1:0]  out_hit_count,
  output logic [lruc_pkg::CNT_W-1:0]  out_access_count,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lruc_pkg::ADDR_W-1:0] paddr,
  input  logic [lruc_pkg::DATA_W-1:0] pwdata,
  output logic [lruc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  // stored key width: the port carries at most 32 bits
  localparam int KW    = (KEY_BITS < lruc_pkg::KEY_W) ? KEY_BITS : lruc_pkg::KEY_W;
  // rank and occupancy widths
  localparam int RW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW    = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OW > lruc_pkg::CAP_W) ? OW : lruc_pkg::CAP_W;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [lruc_pkg::CAP_W-1:0] cap_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == lruc_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == lruc_pkg::REG_CAPACITY) ?
                  lruc_pkg::DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lruc_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[lruc_pkg::CAP_W-1:0];
    end
  end

  // effective capacity: zero acts as one, clipped to ENTRIES
  logic [OW-1:0] cap_eff;
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = OW'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      cap_eff = OW'(ENTRIES);
    end else begin
      cap_eff = OW'(cap_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Input register and flow control
  // ---------------------------------------------------------------------------
  logic          stage_v_r;
  logic [KW-1:0] stage_key_r;
  logic          advance;
  logic          load;

  assign advance  = stage_v_r && (!out_valid || !out_stall);
  assign in_stall = stage_v_r && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (load) begin
      stage_v_r <= 1'b1;
    end else if (advance) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_key_r <= in_key[KW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Directory state
  // ---------------------------------------------------------------------------
  logic [KW-1:0]      key_r   [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [RW-1:0]      rank_r  [ENTRIES];
  logic [OW-1:0]      occ_r;

  // tag compare, hit rank, victim and free slot selection
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim_oh;
  logic [ENTRIES-1:0] free_oh;
  logic [ENTRIES-1:0] write_oh;
  logic [RW-1:0]      hit_rank;
  logic [KW-1:0]      victim_key;
  logic [OW-1:0]      occ_m1;
  logic               hit;
  logic               full;
  logic               evict;
  logic               lower_all_valid;

  assign occ_m1 = occ_r - OW'(1);
  assign full   = (occ_r >= cap_eff);

  always_comb begin
    hit_rank        = '0;
    victim_key      = '0;
    lower_all_valid = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = valid_r[i] && (key_r[i] == stage_key_r);
      // least recent valid entry holds rank occupancy-1
      victim_oh[i] = valid_r[i] && (rank_r[i] == occ_m1[RW-1:0]);
      free_oh[i]   = !valid_r[i] && lower_all_valid;
      lower_all_valid = lower_all_valid && valid_r[i];
      hit_rank     = hit_rank | (match[i] ? rank_r[i] : '0);
      victim_key   = victim_key | (victim_oh[i] ? key_r[i] : '0);
    end
  end

  assign hit      = |match;
  assign evict    = !hit && full;
  assign write_oh = hit ? '0 : (full ? victim_oh : free_oh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      // capacity write flushes the directory
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit) begin
          if (match[i]) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
            rank_r[i] <= rank_r[i] + RW'(1);
          end
        end else if (write_oh[i]) begin
          valid_r[i] <= 1'b1;
          rank_r[i]  <= '0;
        end else if (valid_r[i]) begin
          rank_r[i] <= rank_r[i] + RW'(1);
        end
      end
      if (!hit && !full) begin
        occ_r <= occ_r + OW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (write_oh[i]) begin
          key_r[i] <= stage_key_r;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Counters and result register
  // ---------------------------------------------------------------------------
  logic [lruc_pkg::CNT_W-1:0] hit_cnt_r;
  logic [lruc_pkg::CNT_W-1:0] acc_cnt_r;
  logic [lruc_pkg::CNT_W-1:0] hit_cnt_nxt;
  logic [lruc_pkg::CNT_W-1:0] acc_cnt_nxt;
  logic                       out_valid_r;
  logic                       out_hit_r;
  logic                       out_ev_valid_r;
  logic [lruc_pkg::KEY_W-1:0] out_ev_key_r;

  assign acc_cnt_nxt = (acc_cnt_r == lruc_pkg::CNT_MAX) ? acc_cnt_r
                                                        : acc_cnt_r + lruc_pkg::CNT_W'(1);
  assign hit_cnt_nxt = (!hit || (hit_cnt_r == lruc_pkg::CNT_MAX)) ? hit_cnt_r
                                                                  : hit_cnt_r + lruc_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        hit_cnt_r   <= hit_cnt_nxt;
        acc_cnt_r   <= acc_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit_r      <= hit;
      out_ev_valid_r <= evict;
      out_ev_key_r   <= evict ? lruc_pkg::KEY_W'(victim_key) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_key   = out_ev_key_r;
  assign out_hit_count     = hit_cnt_r;
  assign out_access_count  = acc_cnt_r;

endmodule

>>> design/lruc_checker.sv
module lruc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_hit,
  input logic                        out_evicted_valid,
  input logic [lruc_pkg::KEY_W-1:0]  out_evicted_key,
  input logic [lruc_pkg::CNT_W-1:0]  out_hit_count,
  input logic [lruc_pkg::CNT_W-1:0]  out_access_count
);

  // an eviction only happens on a miss
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_valid |-> !out_hit)
    else $error("eviction reported on a hit");

  // no eviction means a zero key
  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> (out_evicted_key == '0))
    else $error("evicted key not zero without eviction");

  // hits never outnumber accesses, and a hit beat has a nonzero hit count
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit_count <= out_access_count) &&
                  (!out_hit || (out_hit_count != '0)))
    else $error("hit count inconsistent with access count");

  // stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid && out_stall) |->
      out_valid && $stable(out_hit) && $stable(out_evicted_valid) &&
      $stable(out_evicted_key) && $stable(out_hit_count) && $stable(out_access_count))
    else $error("stalled result beat changed");

endmodule

bind lru_cache_hit_counter_top lruc_checker u_lruc_checker (.*);

>>> test/lru_cache_hit_counter_top_tb.sv
module lru_cache_hit_counter_top_tb;

  localparam int NUM_ENTRIES  = lruc_pkg::ENTRIES_DEF;
  localparam int RANK_W       = $clog2(NUM_ENTRIES);
  localparam int MAX_WAIT     = 18;
  // block is two deep, so the settle wait covers anything still in flight
  localparam int SETTLE_CYC   = 8;
  // bound on the slowest correct run, roughly 1000 beats at the longest sender and
  // receiver waits plus config traffic and one long receiver hold, many times over
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 68;
  localparam int LONG_HOLD    = 80;
  localparam int NUM_CAPS     = 13;
  localparam int POOL_MAX     = NUM_ENTRIES + 4;
  localparam int BP_POOL      = 6;
  // at most three beats are ever outstanding, the ring is well above that
  localparam int PEND_DEPTH   = 8;
  localparam int PEND_W       = 3;
  localparam logic [lruc_pkg::ADDR_W-1:0] CAPACITY_ADDR = {lruc_pkg::REG_CAPACITY, 2'b00};

  // one expected result beat
  typedef struct packed {
    logic                       hit;
    logic                       evicted_valid;
    logic [lruc_pkg::KEY_W-1:0] evicted_key;
    logic [lruc_pkg::CNT_W-1:0] hit_count;
    logic [lruc_pkg::CNT_W-1:0] access_count;
  } lookup_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [lruc_pkg::KEY_W-1:0]  in_key;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_hit;
  logic                        out_evicted_valid;
  logic [lruc_pkg::KEY_W-1:0]  out_evicted_key;
  logic [lruc_pkg::CNT_W-1:0]  out_hit_count;
  logic [lruc_pkg::CNT_W-1:0]  out_access_count;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [lruc_pkg::ADDR_W-1:0] paddr;
  logic [lruc_pkg::DATA_W-1:0] pwdata;
  logic [lruc_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  lru_cache_hit_counter_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key),
    .out_hit_count     (out_hit_count),
    .out_access_count  (out_access_count),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // ---------------------------------------------------------------------------
  // Directory shadow: keys, valid bits, recency ranks (0 = most recent),
  // occupancy, the two saturating counters and the capacity register.
  // ---------------------------------------------------------------------------
  logic [lruc_pkg::KEY_W-1:0] dir_key   [NUM_ENTRIES];
  logic                       dir_valid [NUM_ENTRIES];
  logic [RANK_W-1:0]          dir_rank  [NUM_ENTRIES];
  logic [lruc_pkg::CAP_W-1:0] dir_occupancy;
  logic [lruc_pkg::CNT_W-1:0] hits_seen;
  logic [lruc_pkg::CNT_W-1:0] refs_seen;
  logic [lruc_pkg::CAP_W-1:0] capacity_reg;

  // predicted beats in a ring, oldest at pend_rd; the sender advances pend_wr,
  // the checker advances pend_rd
  lookup_t           pending_lookups [PEND_DEPTH];
  logic [PEND_W-1:0] pend_wr;
  logic [PEND_W-1:0] pend_rd;
  lookup_t           oldest_lookup;

  int errors;
  int beats_checked;
  int lookups_sent;
  int caps_written;
  int cycles;
  int tx_max_wait;     // per-phase idling bound of the sender, 0 = no gaps
  int rx_max_wait;     // same for the receiver's stall
  int rx_hold_cycles;  // one-shot long stall request for the receiver

  function automatic int outstanding();
    return int'(PEND_W'(pend_wr - pend_rd));
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle watchdog
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               outstanding());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // capacity 0 behaves as 1, anything above the entry count as the entry count
  function automatic int effective_cap(input logic [lruc_pkg::CAP_W-1:0] cap);
    if (cap == '0) return 1;
    if (cap > NUM_ENTRIES) return NUM_ENTRIES;
    return int'(cap);
  endfunction

  // capacity write: all entries invalid, counters keep running
  function automatic void clear_directory();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_rank[i]  = '0;
    end
    dir_occupancy = '0;
  endfunction

  function automatic lookup_t predict_lookup(input logic [lruc_pkg::KEY_W-1:0] key);
    lookup_t           res;
    int                found;
    int                slot;
    int                lim;
    logic [RANK_W-1:0] hit_rank;
    logic [RANK_W-1:0] oldest;
    res   = '0;
    found = -1;
    slot  = -1;
    lim   = effective_cap(capacity_reg);
    if (refs_seen != lruc_pkg::CNT_MAX) refs_seen++;
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (found < 0 && dir_valid[i] && dir_key[i] == key) found = i;
    if (found >= 0) begin
      // hit: everything more recent than the hit entry ages by one
      hit_rank = dir_rank[found];
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (dir_valid[i] && dir_rank[i] < hit_rank) dir_rank[i]++;
      dir_rank[found] = '0;
      if (hits_seen != lruc_pkg::CNT_MAX) hits_seen++;
      res.hit = 1'b1;
    end else begin
      if (dir_occupancy >= lim) begin
        // full: drop the least recent entry, its slot takes the new key
        oldest = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (dir_valid[i] && (slot < 0 || dir_rank[i] > oldest)) begin
            slot   = i;
            oldest = dir_rank[i];
          end
        end
        if (slot >= 0) begin
          res.evicted_valid = 1'b1;
          res.evicted_key   = dir_key[slot];
          dir_valid[slot]   = 1'b0;
          dir_occupancy--;
        end
      end
      // otherwise the lowest free slot
      if (slot < 0)
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (slot < 0 && !dir_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (dir_valid[i]) dir_rank[i]++;
        dir_key[slot]   = key;
        dir_valid[slot] = 1'b1;
        dir_rank[slot]  = '0;
        dir_occupancy++;
      end
    end
    res.hit_count    = hits_seen;
    res.access_count = refs_seen;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving helpers; all inputs move on the falling edge
  // ---------------------------------------------------------------------------
  // zero about a third of the time so back-to-back beats are common
  function automatic int draw_wait(input int max_wait);
    if (max_wait == 0) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, max_wait);
  endfunction

  // offer one key, hold it until accepted, then log its predicted beat
  task automatic send_key(input logic [lruc_pkg::KEY_W-1:0] key);
    int gap;
    gap = draw_wait(tx_max_wait);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_key   <= key;
    do @(posedge clk); while (in_stall);
    pending_lookups[pend_wr] = predict_lookup(key);
    pend_wr = pend_wr + PEND_W'(1);
    lookups_sent++;
  endtask

  // drop valid and wait until every predicted beat has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write of the capacity register, only with the pipe empty
  task automatic write_capacity(input logic [lruc_pkg::DATA_W-1:0] value);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    capacity_reg = value[lruc_pkg::CAP_W-1:0];
    clear_directory();
    caps_written++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: per beat a random stall run, or one long hold when asked.
  // The long hold is counted here, independent of the sender.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int n;
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = draw_wait(rx_max_wait);
      end
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted beat against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outstanding() == 0) begin
        $error("result beat with no lookup outstanding");
        errors++;
      end else begin
        oldest_lookup = pending_lookups[pend_rd];
        pend_rd = pend_rd + PEND_W'(1);
        check_field("hit", 32'(oldest_lookup.hit), 32'(out_hit));
        check_field("evicted_valid", 32'(oldest_lookup.evicted_valid),
                    32'(out_evicted_valid));
        check_field("evicted_key", oldest_lookup.evicted_key, out_evicted_key);
        check_field("hit_count", oldest_lookup.hit_count, out_hit_count);
        check_field("access_count", oldest_lookup.access_count, out_access_count);
        beats_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // corner keys, capacity 0 / 1 / 2, LRU order, clear on capacity write,
  // saturation of an oversized capacity
  task automatic test_directed();
    tx_max_wait = MAX_WAIT;
    rx_max_wait = MAX_WAIT;
    // reset capacity is 16
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);     // hit
    send_key(32'hAAAA_AAAA);
    send_key(32'h5555_5555);
    send_key(32'hFFFF_FFFF);     // hit
    // zero capacity acts as a single entry
    write_capacity(32'd0);
    send_key(32'd1);
    send_key(32'd1);             // hit
    send_key(32'd2);             // evicts 1
    send_key(32'd2);
    send_key(32'd1);             // evicts 2
    // two entries: LRU victim follows the hit order, not insertion order
    write_capacity(32'd2);
    send_key(32'h1234_5678);
    send_key(32'h8765_4321);
    send_key(32'h1234_5678);     // hit, 8765_4321 now least recent
    send_key(32'hDEAD_BEEF);     // evicts 8765_4321
    send_key(32'h8765_4321);     // evicts 1234_5678
    write_capacity(32'd1);
    send_key(32'd7);
    send_key(32'd8);
    // above the entry count saturates; the clear means key 0 misses
    write_capacity(32'd31);
    send_key(32'h0000_0000);
  endtask

  // random traffic over a set of capacities, keys drawn from a small pool so
  // hits and evictions dominate, some one-bit neighbors and pure noise
  task automatic test_capacity_sweep();
    logic [lruc_pkg::CAP_W-1:0] caps [NUM_CAPS];
    logic [lruc_pkg::KEY_W-1:0] pool [POOL_MAX];
    logic [lruc_pkg::KEY_W-1:0] key;
    int                         pool_n;
    int                         pick;
    caps[0] = 5'd16;
    caps[1] = 5'd1;
    caps[2] = 5'd0;
    caps[3] = 5'd31;
    caps[4] = 5'd17;
    caps[5] = 5'd2;
    caps[6] = 5'd15;
    for (int c = 7; c < NUM_CAPS; c++)
      caps[c] = lruc_pkg::CAP_W'($urandom_range(0, 31));
    for (int c = 0; c < NUM_CAPS; c++) begin
      // upper bits of pwdata are don't-care for the register
      write_capacity({$urandom} & ~32'h1F | 32'(caps[c]));
      tx_max_wait = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
      rx_max_wait = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
      pool_n = $urandom_range(1, effective_cap(caps[c]) + 4);
      for (int p = 0; p < pool_n; p++) begin
        case ($urandom_range(0, 3))
          0:       pool[p] = lruc_pkg::KEY_W'($urandom_range(0, 31));
          1:       pool[p] = 32'hFFFF_FFFF - lruc_pkg::KEY_W'($urandom_range(0, 31));
          default: pool[p] = $urandom;
        endcase
      end
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        key  = pool[$urandom_range(0, pool_n - 1)];
        if (pick >= 90)      key = $urandom;
        else if (pick >= 80) key = key ^ (32'd1 << $urandom_range(0, lruc_pkg::KEY_W - 1));
        send_key(key);
      end
    end
  endtask

  // long receiver hold while the sender keeps offering: the pipe fills and
  // in_stall must hold the input; after a drain, gapped sends, no rx stall
  task automatic test_backpressure();
    logic [lruc_pkg::KEY_W-1:0] pool [BP_POOL];
    write_capacity(32'd4);
    for (int p = 0; p < BP_POOL; p++) pool[p] = $urandom;
    tx_max_wait    = 0;
    rx_max_wait    = MAX_WAIT;
    rx_hold_cycles = LONG_HOLD;
    repeat (40) send_key(pool[$urandom_range(0, BP_POOL - 1)]);
    wait_idle();
    tx_max_wait = MAX_WAIT;
    rx_max_wait = 0;
    repeat (20) send_key(pool[$urandom_range(0, BP_POOL - 1)]);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_key         = '0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    errors         = 0;
    beats_checked  = 0;
    lookups_sent   = 0;
    caps_written   = 0;
    cycles         = 0;
    tx_max_wait    = MAX_WAIT;
    rx_max_wait    = MAX_WAIT;
    rx_hold_cycles = 0;
    pend_wr        = '0;
    pend_rd        = '0;
    capacity_reg   = lruc_pkg::CAP_RESET;
    hits_seen      = '0;
    refs_seen      = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) dir_key[i] = '0;
    clear_directory();

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_capacity_sweep();
    test_backpressure();

    wait_idle();
    if (lookups_sent != beats_checked) begin
      $error("beats sent %0d, results checked %0d", lookups_sent, beats_checked);
      errors++;
    end
    $display("%0d key lookups checked over %0d capacity writes,", beats_checked,
             caps_written);
    $display("with random gaps, back-to-back runs and a long output hold");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
